@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file of the spanning tree engine
// needs a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is held
`define PST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// concurrent check that also runs through reset
`define PST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/pst_pkg.sv @@
// shared types and constants of the spanning tree engine
// no dependencies; used by the cells, the top level and the checker
`default_nettype none

package pst_pkg;

    // input item kinds carried on tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_START = 1'b1;

    // most results one run may give
    localparam int MAX_RESULTS = 8;

    // fixed widths of the item fields
    localparam int VERTEX_BITS = 3;
    localparam int EDGE_BITS   = 8;
    localparam int IN_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS = 16;

    // controls sent from the sequencer to every cell of the row
    typedef struct packed {
        logic clear;
        logic shift;
        logic apply;
        logic search;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ rtl/core/prim_spanning_tree_engine.sv @@
// Prim spanning tree engine: for each joined vertex a start item runs VERTICES ram reads of one
// matrix row, drain, relax, VERTICES search stages through the cell row and decide; at most 8
// results per run; a result held in the output register stalls the run in decide.
// Reset (synchronous, active low) clears control state and starts a clearing pass over all
// VERTICES*VERTICES words of the matrix ram; input tready stays low until it ends.
`default_nettype none

module prim_spanning_tree_engine #(
    parameter int VERTICES    = 8,
    parameter int WEIGHT_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,  // row[2:0] col[5:3] weight[13:6] start_vertex[16:14]
    input  wire logic        i_s_axis_tuser,  // opcode[0]
    // master side
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,  // vertex[2:0] parent[5:3] edge_weight[13:6]
    output logic             o_m_axis_tlast   // last
);

    localparam int VW = $clog2(VERTICES);
    localparam int WB = WEIGHT_BITS;
    localparam int AW = $clog2(VERTICES * VERTICES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(VERTICES * VERTICES - 1);
    localparam logic [6:0]    VCOUNT    = 7'(VERTICES);
    localparam logic [VW-1:0] LAST_K    = VW'(VERTICES - 1);
    localparam logic [3:0]    MAX_CNT   = 4'(pst_pkg::MAX_RESULTS);

    // sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_APPLY  = 3'd4;
    localparam logic [2:0] S_SEARCH = 3'd5;
    localparam logic [2:0] S_DECIDE = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [VW-1:0] r_k, n_k;
    logic [VW-1:0] r_cur, n_cur;
    logic          r_shift;
    logic [3:0]    r_count, n_count;
    logic [VW-1:0] r_pend_vertex, n_pend_vertex;
    logic [VW-1:0] r_pend_parent, n_pend_parent;
    logic [WB-1:0] r_pend_weight, n_pend_weight;
    logic          r_out_valid, n_out_valid;
    logic [2:0]    r_out_vertex, n_out_vertex;
    logic [2:0]    r_out_parent, n_out_parent;
    logic [7:0]    r_out_weight, n_out_weight;
    logic          r_out_last, n_out_last;

    // input fields
    logic       in_op;
    logic [2:0] in_row;
    logic [2:0] in_col;
    logic [7:0] in_weight;
    logic [2:0] in_start;
    assign in_op     = i_s_axis_tuser;
    assign in_row    = i_s_axis_tdata[2:0];
    assign in_col    = i_s_axis_tdata[5:3];
    assign in_weight = i_s_axis_tdata[13:6];
    assign in_start  = i_s_axis_tdata[16:14];

    logic          in_acc;
    logic          wr_ok;
    logic          start_ok;
    logic [12:0]   wr_lin;
    logic [VW+2:0] start_ext;
    logic [VW-1:0] start_idx;
    logic [WB+7:0] weight_ext;
    logic [VW-1:0] row_sel;
    logic [12:0]   row_end;

    assign in_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign wr_ok      = ({4'b0, in_row} < VCOUNT) && ({4'b0, in_col} < VCOUNT);
    assign start_ok   = ({4'b0, in_start} < VCOUNT);
    assign wr_lin     = 13'(in_row) * 13'(VERTICES) + 13'(in_col);
    assign start_ext  = {{VW{1'b0}}, in_start};
    assign start_idx  = start_ext[VW-1:0];
    assign weight_ext = {{WB{1'b0}}, in_weight};

    // cell row wiring
    pst_pkg::t_cell_ctrl cell_ctrl;
    logic [WB-1:0] tok_w  [0:VERTICES];
    logic          cand_v [0:VERTICES];
    logic [WB-1:0] cand_d [0:VERTICES];
    logic [VW-1:0] cand_i [0:VERTICES];
    logic [VW-1:0] cand_p [0:VERTICES];

    // matrix ram
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WB-1:0] ram_wdata;
    logic [WB-1:0] ram_rdata;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (r_state == S_IDLE && in_acc && in_op == pst_pkg::OP_WRITE && wr_ok) begin
            ram_we    = 1'b1;
            ram_waddr = wr_lin[AW-1:0];
            ram_wdata = weight_ext[WB-1:0];
        end
    end

    pst_ram #(
        .WIDTH (WB),
        .DEPTH (VERTICES * VERTICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign tok_w[0]  = ram_rdata;
    assign cand_v[0] = 1'b0;
    assign cand_d[0] = '0;
    assign cand_i[0] = '0;
    assign cand_p[0] = '0;

    genvar g;
    generate
        for (g = 0; g < VERTICES; g++) begin : g_cell
            pst_cell #(
                .VW    (VW),
                .WB    (WB),
                .INDEX (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (cell_ctrl),
                .i_cur        (r_cur),
                .i_w          (tok_w[g]),
                .o_w          (tok_w[g+1]),
                .i_cand_valid (cand_v[g]),
                .i_cand_dist  (cand_d[g]),
                .i_cand_idx   (cand_i[g]),
                .i_cand_par   (cand_p[g]),
                .o_cand_valid (cand_v[g+1]),
                .o_cand_dist  (cand_d[g+1]),
                .o_cand_idx   (cand_i[g+1]),
                .o_cand_par   (cand_p[g+1])
            );
        end
    endgenerate

    // end address of the matrix row that the next step reads, walked downward
    assign row_sel = (r_state == S_IDLE) ? start_idx : cand_i[VERTICES];
    assign row_end = 13'(row_sel) * 13'(VERTICES) + 13'(VERTICES - 1);

    // narrowing of the pending result to the output fields
    logic [VW+2:0] pend_v_ext;
    logic [VW+2:0] pend_p_ext;
    logic [WB+7:0] pend_w_ext;
    logic          out_free;
    logic          run_on;

    assign pend_v_ext = {3'b0, r_pend_vertex};
    assign pend_p_ext = {3'b0, r_pend_parent};
    assign pend_w_ext = {8'b0, r_pend_weight};
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign run_on     = cand_v[VERTICES] && (r_count < MAX_CNT);

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        n_k           = r_k;
        n_cur         = r_cur;
        n_count       = r_count;
        n_pend_vertex = r_pend_vertex;
        n_pend_parent = r_pend_parent;
        n_pend_weight = r_pend_weight;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_out_vertex  = r_out_vertex;
        n_out_parent  = r_out_parent;
        n_out_weight  = r_out_weight;
        n_out_last    = r_out_last;
        cell_ctrl     = '0;
        cell_ctrl.shift = r_shift;
        case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc && in_op == pst_pkg::OP_START && start_ok) begin
                    cell_ctrl.clear = 1'b1;
                    n_cur         = start_idx;
                    n_pend_vertex = start_idx;
                    n_pend_parent = start_idx;
                    n_pend_weight = '0;
                    n_count       = 4'd1;
                    n_addr        = row_end[AW-1:0];
                    n_k           = LAST_K;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                n_addr = r_addr - 1'b1;
                n_k    = r_k - 1'b1;
                if (r_k == '0) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                cell_ctrl.apply = 1'b1;
                n_k     = LAST_K;
                n_state = S_SEARCH;
            end
            S_SEARCH: begin
                cell_ctrl.search = 1'b1;
                n_k = r_k - 1'b1;
                if (r_k == '0) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_vertex = pend_v_ext[2:0];
                    n_out_parent = pend_p_ext[2:0];
                    n_out_weight = pend_w_ext[7:0];
                    n_out_last   = !run_on;
                    if (run_on) begin
                        n_cur         = cand_i[VERTICES];
                        n_pend_vertex = cand_i[VERTICES];
                        n_pend_parent = cand_p[VERTICES];
                        n_pend_weight = cand_d[VERTICES];
                        n_count       = r_count + 1'b1;
                        n_addr        = row_end[AW-1:0];
                        n_k           = LAST_K;
                        n_state       = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_k         <= '0;
            r_cur       <= '0;
            r_shift     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_k         <= n_k;
            r_cur       <= n_cur;
            r_shift     <= (r_state == S_READ);
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_vertex <= n_pend_vertex;
        r_pend_parent <= n_pend_parent;
        r_pend_weight <= n_pend_weight;
        r_out_vertex  <= n_out_vertex;
        r_out_parent  <= n_out_parent;
        r_out_weight  <= n_out_weight;
        r_out_last    <= n_out_last;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b0, r_out_weight, r_out_parent, r_out_vertex};
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/core/pst_ram.sv @@
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/pst_cell.sv @@
// one vertex cell: holds best distance, parent and visited mark of a vertex,
// passes matrix weights and the running minimum candidate to its neighbor; uses pst_pkg
`default_nettype none

module pst_cell #(
    parameter int VW    = 3,
    parameter int WB    = 8,
    parameter int INDEX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pst_pkg::t_cell_ctrl i_ctrl,
    input  wire logic [VW-1:0]     i_cur,
    input  wire logic [WB-1:0]     i_w,
    output logic      [WB-1:0]     o_w,
    input  wire logic              i_cand_valid,
    input  wire logic [WB-1:0]     i_cand_dist,
    input  wire logic [VW-1:0]     i_cand_idx,
    input  wire logic [VW-1:0]     i_cand_par,
    output logic                   o_cand_valid,
    output logic      [WB-1:0]     o_cand_dist,
    output logic      [VW-1:0]     o_cand_idx,
    output logic      [VW-1:0]     o_cand_par
);

    localparam logic [VW-1:0] MY_INDEX = VW'(INDEX);

    logic [WB-1:0] r_w;
    logic [WB-1:0] r_dist;
    logic [VW-1:0] r_par;
    logic          r_vis;
    logic          is_cur;
    logic          take_w;
    logic          own_ok;
    logic          own_wins;

    assign is_cur   = (i_cur == MY_INDEX);
    assign take_w   = !r_vis && !is_cur && (r_w != '0) && ((r_dist == '0) || (r_w < r_dist));
    assign own_ok   = !r_vis && (r_dist != '0);
    assign own_wins = own_ok && (!i_cand_valid || (r_dist < i_cand_dist));

    // weight token shift line
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_w <= i_w;
        end
    end
    assign o_w = r_w;

    // vertex state: clear on reset or start, mark the current vertex visited, relax against the held weight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_dist <= '0;
            r_par  <= '0;
            r_vis  <= 1'b0;
        end else if (i_ctrl.apply) begin
            if (is_cur) begin
                r_vis <= 1'b1;
            end else if (take_w) begin
                r_dist <= r_w;
                r_par  <= i_cur;
            end
        end
    end

    // minimum search stage, lower index keeps ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_cand_valid <= 1'b0;
        end else if (i_ctrl.search) begin
            o_cand_valid <= i_cand_valid || own_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.search) begin
            if (own_wins) begin
                o_cand_dist <= r_dist;
                o_cand_idx  <= MY_INDEX;
                o_cand_par  <= r_par;
            end else begin
                o_cand_dist <= i_cand_dist;
                o_cand_idx  <= i_cand_idx;
                o_cand_par  <= i_cand_par;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pst_checker.sv @@
// port-level checks of the spanning tree engine, bound to the top level
// depends on assert_macros.svh and pst_pkg
`default_nettype none
`include "assert_macros.svh"

module pst_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [15:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tlast
);

    logic in_acc;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // after reset no item leaves and the matrix clearing pass holds off input
    `PST_ASSERT_ALWAYS(a_reset_quiet,
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready,
        "output or input active right after reset")

    // a result that is not the last one means the run is still going
    `PST_ASSERT(a_busy_mid_run,
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready,
        "input taken while a run is in progress")

    // a write item never brings a result forth
    `PST_ASSERT(a_write_silent,
        in_acc && i_s_axis_tuser == pst_pkg::OP_WRITE && !o_m_axis_tvalid |=> !o_m_axis_tvalid,
        "result after a write item")

    // a stalled result holds still
    `PST_ASSERT(a_out_hold,
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast),
        "stalled result changed")

endmodule

bind prim_spanning_tree_engine pst_checker u_pst_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
